[sv/ds22_pkg.sv]
// Shared types and constants of the 2x2 averaging downsampler.
`default_nettype none
package ds22_pkg;

    localparam int PIX_W   = 16;
    localparam int SUM_W   = PIX_W + 1;   // sum of one pixel pair
    localparam int TOT_W   = PIX_W + 2;   // sum of four pixels
    localparam int CNT_W   = 2;           // valid pixels in a pair
    localparam int N_W     = 3;           // valid pixels in a block

    localparam int CFG_WIDTH_W = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_INVALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVALID_CODE = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0] RST_IN_WIDTH     = 13'd640;
    localparam logic                   RST_SKIP_INVALID = 1'b0;
    localparam logic [PIX_W-1:0]       RST_INVALID_CODE = 16'd0;

    localparam int QUEUE_DEPTH = 4;

    // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2**TOT_W
    localparam int DIV3_SHIFT = TOT_W + 2;
    localparam int DIV3_W     = DIV3_SHIFT - 1;
    localparam logic [DIV3_W-1:0] DIV3_MUL = DIV3_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
    localparam int PROD_W     = TOT_W + DIV3_W;

    typedef struct packed {
        logic [CFG_WIDTH_W-1:0] in_width;
        logic                   skip_invalid;
        logic [PIX_W-1:0]       invalid_code;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } t_entry;

    typedef struct packed {
        logic   is_read;   // odd row: read store and emit
        logic   last;
        t_entry pair;
    } t_cmd;

endpackage
`default_nettype wire

[sv/ds22_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ds22_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire                                   i_re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/ds22_fifo.sv]
// Small register queue between the front and the back.
`default_nettype none
module ds22_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[sv/ds22_front.sv]
// Front end: raster position tracking, pair sums and store commands.
`default_nettype none
module ds22_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  ds22_pkg::t_cfg       i_cfg,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [ds22_pkg::PIX_W-1:0] i_pixel,
    input  wire                        i_frame_start,
    input  wire                        i_full,
    output logic                       o_push,
    output ds22_pkg::t_cmd             o_cmd,
    output logic [$clog2(MAX_WIDTH/2)-1:0] o_idx
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WLW = CW + 1;
    localparam int AW  = $clog2(MAX_WIDTH / 2);
    localparam int EXW = (ds22_pkg::CFG_WIDTH_W > WLW) ? ds22_pkg::CFG_WIDTH_W : WLW;

    logic [CW-1:0]              r_col;
    logic                       r_odd;
    logic [ds22_pkg::PIX_W-1:0] r_left;

    logic                       accept;
    logic [EXW-1:0]             w_ext;
    logic [WLW-1:0]             w_eff;
    logic [CW-1:0]              pairs;
    logic [CW-1:0]              col;
    logic                       odd;
    logic [CW-2:0]              half;
    logic                       in_pair;
    logic [WLW-1:0]             col_inc;
    logic                       wrap;
    logic                       left_ok;
    logic                       pix_ok;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        w_ext = EXW'(i_cfg.in_width);
        if (w_ext > EXW'(MAX_WIDTH)) begin
            w_eff = WLW'(MAX_WIDTH);
        end else if (w_ext == '0) begin
            w_eff = WLW'(1);
        end else begin
            w_eff = WLW'(w_ext);
        end
        pairs   = w_eff[WLW-1:1];
        col     = i_frame_start ? '0 : r_col;
        odd     = i_frame_start ? 1'b0 : r_odd;
        half    = col[CW-1:1];
        in_pair = ({1'b0, half} < pairs);
        col_inc = {1'b0, col} + 1'b1;
        wrap    = (col_inc >= w_eff);

        left_ok = (r_left != i_cfg.invalid_code);
        pix_ok  = (i_pixel != i_cfg.invalid_code);

        o_cmd.is_read = odd;
        o_cmd.last    = ({1'b0, half} == pairs - 1'b1);
        if (i_cfg.skip_invalid) begin
            o_cmd.pair.sum = (left_ok ? {1'b0, r_left} : '0)
                           + (pix_ok ? {1'b0, i_pixel} : '0);
            o_cmd.pair.cnt = {1'b0, left_ok} + {1'b0, pix_ok};
        end else begin
            o_cmd.pair.sum = {1'b0, r_left} + {1'b0, i_pixel};
            o_cmd.pair.cnt = 2'd2;
        end
        o_idx  = AW'(half);
        o_push = accept && col[0] && in_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_odd  <= 1'b0;
            r_left <= '0;
        end else if (accept) begin
            if (!col[0]) begin
                r_left <= i_pixel;
            end
            r_col <= wrap ? '0 : col_inc[CW-1:0];
            r_odd <= wrap ? !odd : odd;
        end
    end

endmodule
`default_nettype wire

[sv/ds22_back.sv]
// Back end: line store access, block sum, divide by valid count, output register.
`default_nettype none
module ds22_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  ds22_pkg::t_cfg       i_cfg,
    input  wire                        i_head_valid,
    input  wire  ds22_pkg::t_cmd       i_head_cmd,
    input  wire  [$clog2(MAX_WIDTH/2)-1:0] i_head_idx,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [ds22_pkg::PIX_W-1:0] o_pixel,
    output logic                       o_last
);

    localparam int DEPTH = MAX_WIDTH / 2;

    logic                        adv;
    logic                        rd_en;
    ds22_pkg::t_entry            rd_entry;

    logic                        r_s1_valid;
    ds22_pkg::t_entry            r_s1_cur;
    logic                        r_s1_last;

    logic                        r_s2_valid;
    logic [ds22_pkg::TOT_W-1:0]  r_s2_total;
    logic [ds22_pkg::N_W-1:0]    r_s2_n;
    logic                        r_s2_last;

    logic                        r_s3_valid;
    logic [ds22_pkg::TOT_W-1:0]  r_s3_total;
    logic [ds22_pkg::N_W-1:0]    r_s3_n;
    logic [ds22_pkg::PROD_W-1:0] r_s3_prod;
    logic                        r_s3_last;

    logic                        r_out_valid;
    logic [ds22_pkg::PIX_W-1:0]  r_out_pixel;
    logic                        r_out_last;
    logic [ds22_pkg::PIX_W-1:0]  n_out_pixel;

    assign adv   = !r_out_valid || i_ready;
    assign o_pop = i_head_valid && adv;
    assign rd_en = o_pop && i_head_cmd.is_read;

    ds22_ram #(
        .WIDTH ($bits(ds22_pkg::t_entry)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (o_pop && !i_head_cmd.is_read),
        .i_waddr (i_head_idx),
        .i_wdata (i_head_cmd.pair),
        .i_re    (rd_en),
        .i_raddr (i_head_idx),
        .o_rdata (rd_entry)
    );

    always_comb begin
        if (!i_cfg.skip_invalid) begin
            n_out_pixel = r_s3_total[2 +: ds22_pkg::PIX_W];
        end else begin
            case (r_s3_n)
                3'd0:    n_out_pixel = i_cfg.invalid_code;
                3'd1:    n_out_pixel = r_s3_total[ds22_pkg::PIX_W-1:0];
                3'd2:    n_out_pixel = r_s3_total[1 +: ds22_pkg::PIX_W];
                3'd3:    n_out_pixel = r_s3_prod[ds22_pkg::DIV3_SHIFT +: ds22_pkg::PIX_W];
                default: n_out_pixel = r_s3_total[2 +: ds22_pkg::PIX_W];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_cur    <= i_head_cmd.pair;
            r_s1_last   <= i_head_cmd.last;
            r_s2_total  <= {1'b0, r_s1_cur.sum} + {1'b0, rd_entry.sum};
            r_s2_n      <= {1'b0, r_s1_cur.cnt} + {1'b0, rd_entry.cnt};
            r_s2_last   <= r_s1_last;
            r_s3_total  <= r_s2_total;
            r_s3_n      <= r_s2_n;
            r_s3_prod   <= r_s2_total * ds22_pkg::DIV3_MUL;
            r_s3_last   <= r_s2_last;
            r_out_pixel <= n_out_pixel;
            r_out_last  <= r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= rd_en;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire

[sv/downsample_2x2_average.sv]
// Top level of the 2x2 averaging downsampler.
//
//  port group   dir  tdata                tuser / tlast
//  s_axis       in   [15:0] pixel         tuser[0] frame_start
//  m_axis       out  [15:0] out_pixel     tlast row_last
//  i_cfg_*      in   write: 0 in_width, 1 skip_invalid, 2 invalid_code
//
// One pixel a cycle enters while the 4-entry command queue has room.
// From the queue head a block command passes through the registered stages
// line store read, block sum, divide-by-three multiply and output register.
// The back pipeline stalls as a whole while the output word is not taken.
// Synchronous reset clears position, configuration, queue and pipeline; the
// line store is not cleared.
`default_nettype none
module downsample_2x2_average #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [ds22_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ds22_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [15:0]                         s_axis_tdata,   // pixel
    input  wire  [0:0]                          s_axis_tuser,   // frame_start
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // out_pixel
    output logic                                m_axis_tlast
);

    localparam int AW = $clog2(MAX_WIDTH / 2);
    localparam int QW = $bits(ds22_pkg::t_cmd) + AW;

    ds22_pkg::t_cfg r_cfg;

    logic           push;
    ds22_pkg::t_cmd front_cmd;
    logic [AW-1:0]  front_idx;
    logic           q_full;
    logic           q_valid;
    logic [QW-1:0]  q_data;
    logic           pop;
    ds22_pkg::t_cmd head_cmd;
    logic [AW-1:0]  head_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_width     <= ds22_pkg::RST_IN_WIDTH;
            r_cfg.skip_invalid <= ds22_pkg::RST_SKIP_INVALID;
            r_cfg.invalid_code <= ds22_pkg::RST_INVALID_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ds22_pkg::REG_IN_WIDTH:
                    r_cfg.in_width <= i_cfg_wdata[ds22_pkg::CFG_WIDTH_W-1:0];
                ds22_pkg::REG_SKIP_INVALID:
                    r_cfg.skip_invalid <= i_cfg_wdata[0];
                ds22_pkg::REG_INVALID_CODE:
                    r_cfg.invalid_code <= i_cfg_wdata[ds22_pkg::PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ds22_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser[0]),
        .i_full        (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .o_idx         (front_idx)
    );

    ds22_fifo #(
        .WIDTH (QW),
        .DEPTH (ds22_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_idx, front_cmd}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign head_cmd = q_data[$bits(ds22_pkg::t_cmd)-1:0];
    assign head_idx = q_data[QW-1:$bits(ds22_pkg::t_cmd)];

    ds22_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (q_valid),
        .i_head_cmd   (head_cmd),
        .i_head_idx   (head_idx),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pixel      (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule
`default_nettype wire

[sim/tb_downsample_2x2_average.sv]
// Self-checking testbench of the 2x2 averaging downsampler: directed and random pixel streams.
module tb_downsample_2x2_average;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = 4096;
    localparam int STORE_D      = MAX_W / 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 30;
    localparam int RANDOM_WORDS = 1000;

    typedef struct packed {
        logic [ds22_pkg::PIX_W-1:0] pix;
        logic                       fs;
    } t_pixel_word;

    typedef struct packed {
        logic [ds22_pkg::PIX_W-1:0] avg;
        logic                       last;
    } t_block_avg;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ds22_pkg::CFG_IDX_W-1:0]  i_cfg_idx = ds22_pkg::REG_IN_WIDTH;
    logic [ds22_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata = '0;   // pixel
    logic [0:0]                      s_axis_tuser = '0;   // frame_start
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [15:0]                     m_axis_tdata;        // out_pixel
    logic                            m_axis_tlast;        // row_last

    downsample_2x2_average DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ds22_pkg::t_cfg cfg = {ds22_pkg::RST_IN_WIDTH, ds22_pkg::RST_SKIP_INVALID,
                           ds22_pkg::RST_INVALID_CODE};

    t_pixel_word pixel_q[$];
    t_block_avg  expected_avgs[$];

    // averaging state, advanced on accepted words
    ds22_pkg::t_entry           pair_sums [STORE_D];
    int unsigned                col_pos = 0;
    logic                       row_odd = 1'b0;
    logic [ds22_pkg::PIX_W-1:0] left_pix = '0;

    // position as seen by the stimulus planner
    bit               pair_written [STORE_D];
    int unsigned      plan_col = 0;
    logic             plan_odd = 1'b0;

    int   errors = 0;
    int   cycles = 0;
    int   in_idle_pct = 10;
    int   out_idle_pct = 10;
    int   hold_left = 0;
    logic in_taken = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned row_length(
        input logic [ds22_pkg::CFG_WIDTH_W-1:0] w);
        if (w > MAX_W) return MAX_W;
        if (w == 0) return 1;
        return w;
    endfunction

    function automatic void average_block(input logic [ds22_pkg::PIX_W-1:0] pix,
                                          input logic fs);
        int unsigned                w;
        int unsigned                c;
        int unsigned                idx;
        logic [ds22_pkg::SUM_W-1:0] psum;
        logic [ds22_pkg::CNT_W-1:0] pcnt;
        logic [ds22_pkg::TOT_W-1:0] total;
        logic [ds22_pkg::N_W-1:0]   n;
        logic [ds22_pkg::TOT_W-1:0] avg;
        t_block_avg                 res;
        if (fs) begin
            col_pos = 0;
            row_odd = 1'b0;
        end
        w = row_length(cfg.in_width);
        c = col_pos;
        idx = c / 2;
        if (c % 2 == 0) begin
            left_pix = pix;
        end else if (idx < w / 2) begin
            if (cfg.skip_invalid) begin
                psum = '0;
                pcnt = '0;
                if (left_pix != cfg.invalid_code) begin
                    psum = psum + ds22_pkg::SUM_W'(left_pix);
                    pcnt = pcnt + 2'd1;
                end
                if (pix != cfg.invalid_code) begin
                    psum = psum + ds22_pkg::SUM_W'(pix);
                    pcnt = pcnt + 2'd1;
                end
            end else begin
                psum = ds22_pkg::SUM_W'(left_pix) + ds22_pkg::SUM_W'(pix);
                pcnt = 2'd2;
            end
            if (!row_odd) begin
                pair_sums[idx].sum = psum;
                pair_sums[idx].cnt = pcnt;
            end else begin
                total = ds22_pkg::TOT_W'(psum) + ds22_pkg::TOT_W'(pair_sums[idx].sum);
                n = ds22_pkg::N_W'(pcnt) + ds22_pkg::N_W'(pair_sums[idx].cnt);
                if (!cfg.skip_invalid) begin
                    avg = total >> 2;
                end else if (n == 0) begin
                    avg = ds22_pkg::TOT_W'(cfg.invalid_code);
                end else begin
                    avg = total / ds22_pkg::TOT_W'(n);
                end
                res.avg = avg[ds22_pkg::PIX_W-1:0];
                res.last = (idx == w / 2 - 1);
                expected_avgs.push_back(res);
            end
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_odd = ~row_odd;
        end
    endfunction

    function automatic void plan_word(input logic [ds22_pkg::PIX_W-1:0] pix,
                                      input logic fs);
        int unsigned w;
        int unsigned c;
        t_pixel_word wd;
        w = row_length(cfg.in_width);
        if (fs) begin
            plan_col = 0;
            plan_odd = 1'b0;
        end
        c = plan_col;
        // odd-row pair above which nothing was ever stored: open a new frame instead
        if (plan_odd && c % 2 == 1 && c / 2 < w / 2 && !pair_written[c / 2]) begin
            fs = 1'b1;
            c = 0;
            plan_odd = 1'b0;
        end
        if (!plan_odd && c % 2 == 1 && c / 2 < w / 2) pair_written[c / 2] = 1'b1;
        plan_col = c + 1;
        if (plan_col >= w) begin
            plan_col = 0;
            plan_odd = ~plan_odd;
        end
        wd.pix = pix;
        wd.fs = fs;
        pixel_q.push_back(wd);
    endfunction

    function automatic logic [ds22_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2: return cfg.invalid_code;
            3:       return '0;
            4:       return '1;
            default: return ds22_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [ds22_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ds22_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            ds22_pkg::REG_IN_WIDTH:     cfg.in_width = val[ds22_pkg::CFG_WIDTH_W-1:0];
            ds22_pkg::REG_SKIP_INVALID: cfg.skip_invalid = val[0];
            ds22_pkg::REG_INVALID_CODE: cfg.invalid_code = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_axis_tvalid || expected_avgs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic stream_phase(input int n, input bit start_frame, input int fs_pct);
        for (int i = 0; i < n; i++)
            plan_word(rand_pixel(), (i == 0 && start_frame) || $urandom_range(0, 99) < fs_pct);
        wait_drained();
    endtask

    // input side
    always @(posedge i_clk) begin : take_pixels
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken) average_block(s_axis_tdata, s_axis_tuser[0]);
    end

    always @(negedge i_clk) begin : drive_pixels
        t_pixel_word wd;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                wd = pixel_q.pop_front();
                s_axis_tdata  <= wd.pix;
                s_axis_tuser  <= wd.fs;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(negedge i_clk) begin : drive_ready
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_avgs
        t_block_avg want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_avgs.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, actual out_pixel %h row_last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = expected_avgs.pop_front();
                if (m_axis_tdata !== want.avg) begin
                    errors++;
                    $display("%0t: out_pixel expected %h actual %h",
                             $time, want.avg, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: row_last expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_downsample_2x2_average: errors");
            $finish;
        end
    end

    initial begin : main
        int random_words;
        int w;
        int n;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all-ones block at the smallest width, plain mode
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd2);
        write_reg(ds22_pkg::REG_SKIP_INVALID, 16'd0);
        write_reg(ds22_pkg::REG_INVALID_CODE, 16'd0);
        plan_word(16'hFFFF, 1'b1);
        plan_word(16'hFFFF, 1'b0);
        plan_word(16'hFFFF, 1'b0);
        plan_word(16'hFFFF, 1'b0);
        wait_drained();

        // odd row length, all four pixels invalid
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd3);
        write_reg(ds22_pkg::REG_SKIP_INVALID, 16'd1);
        write_reg(ds22_pkg::REG_INVALID_CODE, 16'hFFFF);
        plan_word(16'hFFFF, 1'b1);
        plan_word(16'hFFFF, 1'b0);
        plan_word(16'd9, 1'b0);
        plan_word(16'hFFFF, 1'b0);
        plan_word(16'hFFFF, 1'b0);
        plan_word(16'd8, 1'b0);
        wait_drained();

        // mode flips between the two rows of a block, both ways
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd2);
        write_reg(ds22_pkg::REG_INVALID_CODE, 16'd0);
        plan_word(16'd0, 1'b1);
        plan_word(16'd5, 1'b0);
        wait_drained();
        write_reg(ds22_pkg::REG_SKIP_INVALID, 16'd0);
        plan_word(16'd0, 1'b0);
        plan_word(16'd7, 1'b0);
        wait_drained();
        plan_word(16'd3, 1'b1);
        plan_word(16'd0, 1'b0);
        wait_drained();
        write_reg(ds22_pkg::REG_SKIP_INVALID, 16'd1);
        plan_word(16'd0, 1'b0);
        plan_word(16'd6, 1'b0);
        wait_drained();

        // row shrinks below the current column
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd8);
        plan_word(16'd1, 1'b1);
        plan_word(16'd2, 1'b0);
        plan_word(16'd3, 1'b0);
        plan_word(16'd4, 1'b0);
        plan_word(16'd5, 1'b0);
        wait_drained();
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd4);
        plan_word(16'd6, 1'b0);
        plan_word(16'd7, 1'b0);
        plan_word(16'd8, 1'b0);
        plan_word(16'd9, 1'b0);
        plan_word(16'd10, 1'b0);
        wait_drained();

        // long stretch with no idling on either side
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd16);
        stream_phase(240, 1'b1, 0);
        in_idle_pct = 10;
        out_idle_pct = 10;

        // oversize width saturates
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd8191);
        stream_phase(60, 1'b1, 0);
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'(MAX_W));
        stream_phase(40, 1'b0, 0);

        // long output stall while words keep coming
        write_reg(ds22_pkg::REG_IN_WIDTH, 16'd4);
        write_reg(ds22_pkg::REG_SKIP_INVALID, 16'd0);
        hold_left = 400;
        stream_phase(160, 1'b1, 1);

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: w = $urandom_range(0, 5);
                4:          w = $urandom_range(41, 300);
                default:    w = $urandom_range(2, 40);
            endcase
            write_reg(ds22_pkg::REG_IN_WIDTH, 16'(w));
            if ($urandom_range(0, 9) < 7)
                write_reg(ds22_pkg::REG_SKIP_INVALID, 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 3))
                    0:       write_reg(ds22_pkg::REG_INVALID_CODE, 16'd0);
                    1:       write_reg(ds22_pkg::REG_INVALID_CODE, 16'hFFFF);
                    default: write_reg(ds22_pkg::REG_INVALID_CODE, 16'($urandom));
                endcase
            end
            n = $urandom_range(30, 160);
            stream_phase(n, $urandom_range(0, 9) < 7, 1);
            if (w >= 2) random_words += n;
        end

        wait_drained();
        if (errors == 0) begin
            $display("tb_downsample_2x2_average: clean");
        end else begin
            $display("tb_downsample_2x2_average: errors");
        end
        $finish;
    end

endmodule
